FILE: src/tgad_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; used by the decode step, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package tgad_pkg;

    localparam int unsigned PIX_COUNT_W = 25;
    localparam int unsigned CFG_DATA_W  = 25;
    localparam int unsigned CFG_INDEX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_CHANNELS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RLE_CODED     = 2'd2;

    localparam logic [PIX_COUNT_W-1:0] PIX_COUNT_MAX = {PIX_COUNT_W{1'b1}};

    // Packet header fields
    localparam int unsigned  HDR_REPEAT_BIT = 7;
    localparam logic [7:0]   HDR_COUNT_MASK = 8'h7F;

    localparam logic [7:0]   ALPHA_LOW_LIMIT = 8'd250;
    localparam logic [7:0]   ALPHA_OPAQUE    = 8'd255;

    typedef struct packed {
        logic                   expect_header;
        logic                   packet_is_repeat;
        logic [7:0]             packet_pixels_left;
        logic [1:0]             channel_index;
        logic [23:0]            pixel_bytes;        // B 7:0, G 15:8, R 23:16
        logic [PIX_COUNT_W-1:0] image_pixels_left;
        logic                   low_alpha_flag;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{
        expect_header:      1'b1,
        packet_is_repeat:   1'b0,
        packet_pixels_left: 8'd0,
        channel_index:      2'd0,
        pixel_bytes:        24'd0,
        image_pixels_left:  '0,
        low_alpha_flag:     1'b0
    };

    typedef struct packed {
        logic [PIX_COUNT_W-1:0] pixel_load;   // count already clipped to the cap
        logic                   four_channels;
        logic                   rle_coded;
    } dec_cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] run_length;
        logic       last_pixel;
        logic       alpha_seen;
    } pixel_t;

endpackage

`default_nettype wire

FILE: src/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder: handshake, config and state.
// Depends on tgad_pkg and tgad_step.
`timescale 1ns / 1ps
`default_nettype none

// Decodes TGA pixel data one byte per beat into RGBA pixels. Every byte is
// taken into an input register; from there the decode step consumes it,
// updates the packet/pixel state and, on the closing byte of a pixel, loads
// the result register. Throughput is one byte per clock: the input register
// keeps taking bytes while a pixel waits in the result register, and only a
// byte that closes a pixel waits for that register to drain. In run-length
// mode a repeat packet yields a single beat whose m_run_length is the
// packet count, clipped to the pixels still left. Assert s_image_start on
// the first byte of each image; it reloads the pixel count (clipped to
// MAX_SIDE squared) and clears all decoding state. Bytes past the last
// pixel, or before any image start, are swallowed. Configuration writes
// take effect immediately and must only be issued while the decoder is
// idle.
module tga_rle_pixel_decoder #(
    parameter int unsigned MAX_SIDE = 4096
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             cfg_wr_en,
    input  wire logic [tgad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tgad_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_data_byte,
    input  wire logic                             s_image_start,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [7:0]                            m_red,
    output logic [7:0]                            m_green,
    output logic [7:0]                            m_blue,
    output logic [7:0]                            m_alpha,
    output logic [7:0]                            m_run_length,
    output logic                                  m_last_pixel,
    output logic                                  m_alpha_seen
);

    // Cap on the pixel count, folded into the 25-bit count range
    localparam longint unsigned CAP_FULL = 64'(MAX_SIDE) * 64'(MAX_SIDE);
    localparam logic [tgad_pkg::PIX_COUNT_W-1:0] CAP_CLIP =
        (CAP_FULL > 64'(tgad_pkg::PIX_COUNT_MAX)) ? tgad_pkg::PIX_COUNT_MAX
                                                  : tgad_pkg::PIX_COUNT_W'(CAP_FULL);

    // Configuration registers
    logic [tgad_pkg::PIX_COUNT_W-1:0] pixel_count_reg;
    logic                             four_channels_reg;
    logic                             rle_coded_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // Decoder state
    tgad_pkg::dec_state_t state_reg;
    tgad_pkg::dec_state_t state_next;

    // Result register
    logic             out_valid_reg;
    tgad_pkg::pixel_t out_pixel_reg;

    tgad_pkg::dec_cfg_t cfg;
    tgad_pkg::pixel_t   step_pixel;
    logic               step_valid;
    logic               out_free;
    logic               fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg   <= tgad_pkg::PIX_COUNT_W'(1);
            four_channels_reg <= 1'b1;
            rle_coded_reg     <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tgad_pkg::CFG_PIXEL_COUNT:   pixel_count_reg   <= cfg_wdata;
                tgad_pkg::CFG_FOUR_CHANNELS: four_channels_reg <= cfg_wdata[0];
                tgad_pkg::CFG_RLE_CODED:     rle_coded_reg     <= cfg_wdata[0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    always_comb begin
        cfg.pixel_load    = (pixel_count_reg > CAP_CLIP) ? CAP_CLIP : pixel_count_reg;
        cfg.four_channels = four_channels_reg;
        cfg.rle_coded     = rle_coded_reg;
    end

    tgad_step u_step (
        .st          (state_reg),
        .cfg         (cfg),
        .data_byte   (in_byte_reg),
        .image_start (in_start_reg),
        .st_next     (state_next),
        .res_valid   (step_valid),
        .res         (step_pixel)
    );

    // A held byte retires unless it closes a pixel and the result slot is busy
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && (!step_valid || out_free);
    assign s_ready  = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_image_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tgad_pkg::STATE_RESET;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fire && step_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && step_valid) begin
            out_pixel_reg <= step_pixel;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_red        = out_pixel_reg.red;
    assign m_green      = out_pixel_reg.green;
    assign m_blue       = out_pixel_reg.blue;
    assign m_alpha      = out_pixel_reg.alpha;
    assign m_run_length = out_pixel_reg.run_length;
    assign m_last_pixel = out_pixel_reg.last_pixel;
    assign m_alpha_seen = out_pixel_reg.alpha_seen;

endmodule

`default_nettype wire

FILE: src/tgad_step.sv
// One-byte decode step: next decoder state and optional pixel result.
// Pure combinational; depends on tgad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgad_step (
    input  wire tgad_pkg::dec_state_t st,
    input  wire tgad_pkg::dec_cfg_t   cfg,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 image_start,
    output tgad_pkg::dec_state_t      st_next,
    output logic                      res_valid,
    output tgad_pkg::pixel_t          res
);

    always_comb begin
        tgad_pkg::dec_state_t            cur;
        tgad_pkg::dec_state_t            nxt;
        logic [1:0]                      last_ch;
        logic [7:0]                      run;
        logic [7:0]                      alpha;
        logic [7:0]                      red;
        logic [tgad_pkg::PIX_COUNT_W-1:0] left_after;

        cur = st;
        if (image_start) begin
            cur = tgad_pkg::STATE_RESET;
            cur.image_pixels_left = cfg.pixel_load;
        end

        nxt        = cur;
        res_valid  = 1'b0;
        res        = '0;
        last_ch    = cfg.four_channels ? 2'd3 : 2'd2;
        run        = 8'd1;
        alpha      = tgad_pkg::ALPHA_OPAQUE;
        red        = data_byte;
        left_after = cur.image_pixels_left;

        if (cur.image_pixels_left != '0) begin
            if (cfg.rle_coded && (cur.expect_header || cur.packet_pixels_left == 8'd0)) begin
                nxt.packet_is_repeat   = data_byte[tgad_pkg::HDR_REPEAT_BIT];
                nxt.packet_pixels_left = (data_byte & tgad_pkg::HDR_COUNT_MASK) + 8'd1;
                nxt.expect_header      = 1'b0;
                nxt.channel_index      = 2'd0;
            end else if (cur.channel_index < last_ch) begin
                unique case (cur.channel_index)
                    2'd0:    nxt.pixel_bytes[7:0]   = data_byte;
                    2'd1:    nxt.pixel_bytes[15:8]  = data_byte;
                    2'd2:    nxt.pixel_bytes[23:16] = data_byte;
                    default: nxt.pixel_bytes       = cur.pixel_bytes;
                endcase
                nxt.channel_index = cur.channel_index + 2'd1;
            end else begin
                // closing byte of the pixel
                if (cfg.four_channels) begin
                    red   = cur.pixel_bytes[23:16];
                    alpha = data_byte;
                end
                nxt.channel_index = 2'd0;

                if (cfg.rle_coded) begin
                    if (cur.packet_is_repeat) begin
                        if ({{(tgad_pkg::PIX_COUNT_W-8){1'b0}}, cur.packet_pixels_left}
                                > cur.image_pixels_left) begin
                            run = cur.image_pixels_left[7:0];
                        end else begin
                            run = cur.packet_pixels_left;
                        end
                        nxt.packet_pixels_left = 8'd0;
                    end else begin
                        nxt.packet_pixels_left = cur.packet_pixels_left - 8'd1;
                    end
                    if (nxt.packet_pixels_left == 8'd0) begin
                        nxt.expect_header = 1'b1;
                    end
                end

                left_after = cur.image_pixels_left
                           - {{(tgad_pkg::PIX_COUNT_W-8){1'b0}}, run};
                nxt.image_pixels_left = left_after;
                if (alpha < tgad_pkg::ALPHA_LOW_LIMIT) begin
                    nxt.low_alpha_flag = 1'b1;
                end

                res_valid      = 1'b1;
                res.red        = red;
                res.green      = cur.pixel_bytes[15:8];
                res.blue       = cur.pixel_bytes[7:0];
                res.alpha      = alpha;
                res.run_length = run;
                res.last_pixel = (left_after == '0);
                res.alpha_seen = nxt.low_alpha_flag;
            end
        end

        st_next = nxt;
    end

endmodule

`default_nettype wire

FILE: src/tgad_checker.sv
// Port-level checks for the TGA run-length pixel decoder, bound to the top.
// Depends on tgad_pkg and tga_rle_pixel_decoder.
`timescale 1ns / 1ps
`default_nettype none

module tgad_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [7:0]                       m_red,
    input wire logic [7:0]                       m_green,
    input wire logic [7:0]                       m_blue,
    input wire logic [7:0]                       m_alpha,
    input wire logic [7:0]                       m_run_length,
    input wire logic                             m_last_pixel,
    input wire logic                             m_alpha_seen
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
            && $stable(m_blue) && $stable(m_alpha) && $stable(m_run_length)
            && $stable(m_last_pixel) && $stable(m_alpha_seen))
        else $error("result beat changed while stalled");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // every pixel covers at least one position
    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_run_length != 8'd0)
        else $error("zero run length");

    // the sticky flag includes the current pixel
    a_alpha_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_alpha < tgad_pkg::ALPHA_LOW_LIMIT) |-> m_alpha_seen)
        else $error("low alpha not flagged");

endmodule

bind tga_rle_pixel_decoder tgad_checker u_tgad_checker (.*);

`default_nettype wire

FILE: sim/tb_tga_rle_pixel_decoder.sv
// Self-checking testbench for tga_rle_pixel_decoder: directed and random byte streams.
// Depends on tgad_pkg and the decoder RTL; the scoreboard class below predicts every pixel.
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder;

    localparam int unsigned DEC_MAX_SIDE  = 4096;
    localparam logic [tgad_pkg::PIX_COUNT_W-1:0] PIX_CAP =
        tgad_pkg::PIX_COUNT_W'(DEC_MAX_SIDE * DEC_MAX_SIDE);
    localparam int unsigned RANDOM_BYTES  = 800;     // decoded bytes in the random part
    localparam int unsigned QUIET_TAIL    = 150;     // last bytes run with no idling
    localparam int unsigned DRAIN_CYCLES  = 4;       // covers the input register and the result register
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    // ------------------------------------------------------------------
    // Pixel predictor and expectation store
    // ------------------------------------------------------------------
    class pixel_scoreboard;
        // register copy
        logic [tgad_pkg::PIX_COUNT_W-1:0] cnt_reg;
        logic                             four_reg;
        logic                             rle_reg;
        // decode state
        logic                             want_header;
        logic                             rep_packet;
        logic [7:0]                       pkt_left;
        logic [1:0]                       chan;
        logic [23:0]                      bytes_held;
        logic [tgad_pkg::PIX_COUNT_W-1:0] img_left;
        logic                             low_alpha;
        logic                             img_done;

        tgad_pkg::pixel_t expected_q[$];
        int               errors;
        int unsigned      used_bytes;   // bytes that the decoder actually consumed

        function new();
            errors     = 0;
            used_bytes = 0;
            cnt_reg    = tgad_pkg::PIX_COUNT_W'(1);
            four_reg   = 1'b1;
            rle_reg    = 1'b1;
            clear_state();
        endfunction

        function void clear_state();
            want_header = 1'b1;
            rep_packet  = 1'b0;
            pkt_left    = '0;
            chan        = '0;
            bytes_held  = '0;
            img_left    = '0;
            low_alpha   = 1'b0;
            img_done    = 1'b0;
        endfunction

        function void write_reg(logic [tgad_pkg::CFG_INDEX_W-1:0] idx,
                                logic [tgad_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                tgad_pkg::CFG_PIXEL_COUNT:   cnt_reg  = val[tgad_pkg::PIX_COUNT_W-1:0];
                tgad_pkg::CFG_FOUR_CHANNELS: four_reg = val[0];
                tgad_pkg::CFG_RLE_CODED:     rle_reg  = val[0];
                default: ;
            endcase
        endfunction

        // Called on every accepted input beat
        function void note_byte(logic [7:0] b, logic st);
            tgad_pkg::pixel_t                 px;
            logic [1:0]                       final_chan;
            logic [tgad_pkg::PIX_COUNT_W-1:0] run;
            if (st) begin
                clear_state();
                img_left = (cnt_reg > PIX_CAP) ? PIX_CAP : cnt_reg;
                img_done = (img_left == 0);
            end
            if (img_done || img_left == 0) return;
            used_bytes++;

            if (rle_reg && (want_header || pkt_left == 0)) begin
                rep_packet  = b[tgad_pkg::HDR_REPEAT_BIT];
                pkt_left    = (b & tgad_pkg::HDR_COUNT_MASK) + 8'd1;
                want_header = 1'b0;
                chan        = '0;
                return;
            end

            final_chan = four_reg ? 2'd3 : 2'd2;
            if (chan < final_chan) begin
                bytes_held[8*chan +: 8] = b;
                chan = chan + 2'd1;
                return;
            end

            // closing byte of the pixel
            px.blue  = bytes_held[7:0];
            px.green = bytes_held[15:8];
            if (four_reg) begin
                px.red   = bytes_held[23:16];
                px.alpha = b;
            end else begin
                px.red   = b;      // also when a fourth byte was due
                px.alpha = tgad_pkg::ALPHA_OPAQUE;
            end
            chan = '0;

            run = tgad_pkg::PIX_COUNT_W'(1);
            if (rle_reg) begin
                if (rep_packet) begin
                    run      = (tgad_pkg::PIX_COUNT_W'(pkt_left) > img_left)
                             ? img_left : tgad_pkg::PIX_COUNT_W'(pkt_left);
                    pkt_left = '0;
                end else begin
                    pkt_left = pkt_left - 8'd1;
                end
                if (pkt_left == 0) want_header = 1'b1;
            end
            img_left = img_left - run;
            if (px.alpha < tgad_pkg::ALPHA_LOW_LIMIT) low_alpha = 1'b1;
            if (img_left == 0) img_done = 1'b1;

            px.run_length = run[7:0];
            px.last_pixel = img_done;
            px.alpha_seen = low_alpha;
            expected_q.insert(expected_q.size(), px);
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        // Called on every accepted result beat
        function void check_pixel(tgad_pkg::pixel_t got);
            tgad_pkg::pixel_t want;
            if (expected_q.size() == 0) begin
                $error("pixel beat with nothing expected: r %0d g %0d b %0d a %0d run %0d",
                       got.red, got.green, got.blue, got.alpha, got.run_length);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("red",        want.red,        got.red);
            compare("green",      want.green,      got.green);
            compare("blue",       want.blue,       got.blue);
            compare("alpha",      want.alpha,      got.alpha);
            compare("run_length", want.run_length, got.run_length);
            compare("last_pixel", 8'(want.last_pixel), 8'(got.last_pixel));
            compare("alpha_seen", 8'(want.alpha_seen), 8'(got.alpha_seen));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [tgad_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tgad_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                             s_valid;
    logic                             s_ready;
    logic [7:0]                       s_data_byte;
    logic                             s_image_start;
    logic                             m_valid;
    logic                             m_ready;
    logic [7:0]                       m_red;
    logic [7:0]                       m_green;
    logic [7:0]                       m_blue;
    logic [7:0]                       m_alpha;
    logic [7:0]                       m_run_length;
    logic                             m_last_pixel;
    logic                             m_alpha_seen;

    tga_rle_pixel_decoder #(
        .MAX_SIDE(DEC_MAX_SIDE)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_image_start(s_image_start),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha      (m_alpha),
        .m_run_length (m_run_length),
        .m_last_pixel (m_last_pixel),
        .m_alpha_seen (m_alpha_seen)
    );

    pixel_scoreboard sb;
    bit              src_gaps;     // random idle bursts on the byte side
    bit              sink_stalls;  // random backpressure on the pixel side
    logic            start_flag;   // next byte opens a new image

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case something hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end

    // m_ready: random stall bursts, driven on the falling edge
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_ready    <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Pixel beats are checked at the rising edge they are taken
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pixel({m_red, m_green, m_blue, m_alpha,
                            m_run_length, m_last_pixel, m_alpha_seen});
    end

    // ------------------------------------------------------------------
    // Drivers. Every task starts and ends on a falling edge.
    // ------------------------------------------------------------------

    // One byte beat. Valid is only dropped when an idle burst is inserted,
    // so it never sees two assignments in one step.
    task automatic send_beat(input logic [7:0] b, input logic st);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_image_start <= st;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b, st);
        @(negedge aclk);
    endtask

    // Sender stops until every predicted pixel is out, then lets the
    // pipeline settle (bytes that close no pixel may still be in flight).
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_beat(input logic [tgad_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [tgad_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // Writes all three registers back to back while the decoder is idle
    task automatic set_mode(input logic [tgad_pkg::PIX_COUNT_W-1:0] cnt, input logic four,
                            input logic rle);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_beat(tgad_pkg::CFG_PIXEL_COUNT,   tgad_pkg::CFG_DATA_W'(cnt));
        cfg_beat(tgad_pkg::CFG_FOUR_CHANNELS, tgad_pkg::CFG_DATA_W'(four));
        cfg_beat(tgad_pkg::CFG_RLE_CODED,     tgad_pkg::CFG_DATA_W'(rle));
        cfg_wr_en <= 1'b0;
    endtask

    // Byte of the current image; the first one carries the image start
    task automatic put(input logic [7:0] b);
        send_beat(b, start_flag);
        start_flag = 1'b0;
    endtask

    task automatic put_pixel(input logic four, input bit low_ok);
        logic [7:0] a;
        put(8'($urandom_range(0, 255)));
        put(8'($urandom_range(0, 255)));
        put(8'($urandom_range(0, 255)));
        if (four) begin
            if (!low_ok)
                a = 8'($urandom_range(250, 255));
            else if ($urandom_range(0, 3) == 0)
                a = 8'($urandom_range(248, 251));    // around the low-alpha threshold
            else
                a = 8'($urandom_range(0, 255));
            put(a);
        end
    endtask

    // Well-formed image of npix pixels with random packets and content
    task automatic send_image(input int npix, input logic four, input logic rle,
                              input bit low_ok);
        int   left;
        int   cnt;
        int   i;
        logic rep;
        start_flag = 1'b1;
        left       = npix;
        while (left > 0) begin
            if (!rle) begin
                put_pixel(four, low_ok);
                left--;
            end else begin
                rep = 1'($urandom_range(0, 1));
                if (rep || $urandom_range(0, 31) == 0)
                    cnt = int'($urandom_range(1, 128));
                else
                    cnt = int'($urandom_range(1, 6));
                put({rep, 7'(cnt - 1)});
                if (rep) begin
                    put_pixel(four, low_ok);
                    left -= cnt;                 // may overshoot: run gets clipped
                end else begin
                    for (i = 0; i < cnt && left > 0; i++) begin
                        put_pixel(four, low_ok);
                        left--;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [tgad_pkg::PIX_COUNT_W-1:0] cur_cnt;
        logic                             cur_four;
        logic                             cur_rle;
        int                               npix;
        int unsigned                      base;

        sb            = new();
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data_byte   = '0;
        s_image_start = 1'b0;
        src_gaps      = 1'b1;
        sink_stalls   = 1'b1;
        start_flag    = 1'b0;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed ---
        // no image started yet: swallowed
        send_beat(8'h5A, 1'b0);
        send_beat(8'hA5, 1'b0);

        // reset config (1 pixel, BGRA, RLE): repeat of 128 clipped to 1,
        // alpha 0 sets the sticky flag, then a trailing byte is ignored
        start_flag = 1'b1;
        put(8'hFF);
        put(8'h00);
        put(8'hFF);
        put(8'h00);
        put(8'h00);
        put(8'hAA);

        // zero pixel count: image is complete from the start
        set_mode('0, 1'b1, 1'b1);
        start_flag = 1'b1;
        put(8'h80);

        // oversized count saturates; plain BGR
        set_mode(tgad_pkg::PIX_COUNT_MAX, 1'b0, 1'b0);
        start_flag = 1'b1;
        put(8'hFF);
        put(8'h00);
        put(8'hFF);

        // mode changes in the middle of an image
        set_mode(25'd3, 1'b1, 1'b1);
        start_flag = 1'b1;
        put(8'h01);          // raw packet of two
        put(8'h11);
        put(8'h22);
        put(8'h33);
        set_mode(25'd3, 1'b0, 1'b1);
        put(8'h44);          // fourth byte due, now closes the pixel as red
        set_mode(25'd3, 1'b1, 1'b0);
        put(8'h01);          // plain mode: packet state left alone
        put(8'h02);
        put(8'h03);
        put(8'd250);         // alpha at the threshold is not low
        set_mode(25'd3, 1'b1, 1'b1);
        put(8'hFE);          // back in RLE: rest of the raw packet
        put(8'h7F);
        put(8'h80);
        put(8'd249);

        // --- random ---
        cur_cnt  = 25'd3;
        cur_four = 1'b1;
        cur_rle  = 1'b1;
        base     = sb.used_bytes;
        while (sb.used_bytes - base < RANDOM_BYTES) begin
            if (sb.used_bytes - base > RANDOM_BYTES - QUIET_TAIL) begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end else begin
                src_gaps    = ($urandom_range(0, 4) != 0);
                sink_stalls = ($urandom_range(0, 4) != 0);
            end

            if ($urandom_range(0, 3) != 0) begin
                cur_four = 1'($urandom_range(0, 1));
                cur_rle  = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 15))
                    0:       cur_cnt = '0;
                    1:       cur_cnt = tgad_pkg::PIX_COUNT_W'(
                                 $urandom_range(PIX_CAP + 1, tgad_pkg::PIX_COUNT_MAX));
                    2:       cur_cnt = tgad_pkg::PIX_COUNT_MAX;
                    3:       cur_cnt = PIX_CAP;
                    default: cur_cnt = cur_rle ? tgad_pkg::PIX_COUNT_W'($urandom_range(1, 150))
                                               : tgad_pkg::PIX_COUNT_W'($urandom_range(1, 8));
                endcase
                set_mode(cur_cnt, cur_four, cur_rle);
            end else if ($urandom_range(0, 3) == 0) begin
                wait_drain();   // sender holds off with no register change
            end

            if (cur_cnt == 0) begin
                start_flag = 1'b1;
                put(8'($urandom_range(0, 255)));
                put(8'($urandom_range(0, 255)));
            end else begin
                npix = (cur_cnt > 150) ? int'($urandom_range(5, 30)) : int'(cur_cnt);
                if ($urandom_range(0, 7) == 0)
                    npix = npix / 2;             // cut short, next start restarts
                send_image(npix, cur_four, cur_rle, $urandom_range(0, 2) != 0);
            end

            // stray bytes: trailing data or a spurious image start
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end

        // --- wind down ---
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (sb.expected_q.size() != 0)
                $error("%0d expected pixel beats never arrived", sb.expected_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/tgad_pkg.sv
src/tgad_step.sv
src/tga_rle_pixel_decoder.sv
src/tgad_checker.sv
sim/tb_tga_rle_pixel_decoder.sv
